>>> rtl/core/trmm_pkg.sv
// Shared types and constants for the upper triangular matrix multiply unit.
// No dependencies; imported by every module of the block except trmm_store.
`default_nettype none

package trmm_pkg;

  // Fixed field widths
  localparam int unsigned CNT_W     = 5;   // row_count / col_count registers
  localparam int unsigned IDX_W     = 4;   // row / col request fields
  localparam int unsigned VAL_W     = 16;  // element value and result value
  localparam int unsigned ALPHA_W   = 16;  // alpha_scale register
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned MODE_W    = 2;

  // Shared multiplier operand widths
  localparam int unsigned MA_W      = 20;
  localparam int unsigned MB_W      = 17;
  // Low chunk of the dot-product sum for the two-pass alpha scaling
  localparam int unsigned LO_W      = 19;
  localparam int unsigned RND_SHIFT = 16;
  localparam int          RoundHalf = 1 << (RND_SHIFT - 1);
  localparam int          OneQ8     = 256;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'h0100;

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_A    = 2'd0,
    MODE_WR_B    = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_RD_B    = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS  = 2'd0,
    CFG_COLS  = 2'd1,
    CFG_UNIT  = 2'd2,
    CFG_ALPHA = 2'd3
  } cfg_idx_e;

  // One operation handed to the shared multiply unit
  typedef struct packed {
    logic vld;   // operation present
    logic clr;   // first term of a dot product
    logic last;  // last term of a dot product
    logic scl;   // alpha scaling pass
    logic hi;    // high chunk of the scaling pass
    logic unit;  // take the diagonal of A as one
  } mul_op_t;

  // Status back from the multiply unit to the sequencer
  typedef struct packed {
    logic sum_done;  // dot product complete in the accumulator
    logic res_vld;   // rounded, saturated element ready
  } mul_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/trmm_store.sv
// A and B element memories, one write and one registered read port each.
// No package dependency.
`default_nettype none

module trmm_store #(
  parameter int unsigned EW = 16,
  parameter int unsigned AW = 8
) (
  input  logic          clk_i,
  input  logic          a_we_i,
  input  logic [AW-1:0] a_waddr_i,
  input  logic [EW-1:0] a_wdata_i,
  input  logic [AW-1:0] a_raddr_i,
  output logic [EW-1:0] a_rdata_o,
  input  logic          b_we_i,
  input  logic [AW-1:0] b_waddr_i,
  input  logic [EW-1:0] b_wdata_i,
  input  logic [AW-1:0] b_raddr_i,
  output logic [EW-1:0] b_rdata_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [EW-1:0] a_mem_q [DEPTH];
  logic [EW-1:0] b_mem_q [DEPTH];
  logic [EW-1:0] a_rdata_q;
  logic [EW-1:0] b_rdata_q;

  always_ff @(posedge clk_i) begin
    if (a_we_i) begin
      a_mem_q[a_waddr_i] <= a_wdata_i;
    end
    a_rdata_q <= a_mem_q[a_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (b_we_i) begin
      b_mem_q[b_waddr_i] <= b_wdata_i;
    end
    b_rdata_q <= b_mem_q[b_raddr_i];
  end

  assign a_rdata_o = a_rdata_q;
  assign b_rdata_o = b_rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/trmm_mul.sv
// Shared multiply-accumulate unit: dot product, two-pass alpha scaling,
// rounding and saturation. Depends on trmm_pkg.
`default_nettype none

module trmm_mul #(
  parameter int unsigned EW = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  trmm_pkg::mul_op_t                    op_i,
  input  logic [EW-1:0]                        a_rdata_i,
  input  logic [EW-1:0]                        b_rdata_i,
  input  logic signed [trmm_pkg::ALPHA_W-1:0]  alpha_i,
  output trmm_pkg::mul_sts_t                   sts_o,
  output logic [EW-1:0]                        res_o
);

  import trmm_pkg::*;

  localparam int unsigned SUM_W = 2 * EW + 5;
  localparam int unsigned FIN_W = SUM_W + ALPHA_W;
  localparam int unsigned RND_W = FIN_W - RND_SHIFT;
  localparam int unsigned PRD_W = MA_W + MB_W;

  localparam logic signed [RND_W-1:0] MAX_POS = RND_W'((1 << (EW - 1)) - 1);
  localparam logic signed [RND_W-1:0] MIN_NEG = ~MAX_POS;

  mul_op_t                 op1_q, op2_q;
  logic signed [MA_W-1:0]  opa;
  logic signed [MB_W-1:0]  opb;
  logic signed [PRD_W-1:0] prod_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [FIN_W-1:0] fin_q, fin_d, fin_add, rnd_sum;
  logic signed [RND_W-1:0] rnd;
  logic [EW-1:0]           res_d, res_q;
  logic                    fin_vld_q, res_vld_q;

  // Operand select: memory data for dot-product terms, sum chunks for scaling
  always_comb begin
    if (op1_q.scl) begin
      opb = MB_W'(alpha_i);
      if (op1_q.hi) begin
        opa = MA_W'(signed'(sum_q[SUM_W-1:LO_W]));
      end else begin
        opa = MA_W'(sum_q[LO_W-1:0]);
      end
    end else begin
      opb = MB_W'(signed'(b_rdata_i));
      if (op1_q.unit) begin
        opa = MA_W'(OneQ8);
      end else begin
        opa = MA_W'(signed'(a_rdata_i));
      end
    end
  end

  // Accumulate
  always_comb begin
    sum_d   = sum_q;
    fin_d   = fin_q;
    fin_add = op2_q.hi ? (FIN_W'(prod_q) <<< LO_W) : FIN_W'(prod_q);
    if (op2_q.vld && !op2_q.scl) begin
      sum_d = (op2_q.clr ? SUM_W'(0) : sum_q) + SUM_W'(prod_q);
    end
    if (op2_q.vld && op2_q.scl) begin
      fin_d = (op2_q.hi ? fin_q : FIN_W'(0)) + fin_add;
    end
  end

  // Round to nearest, ties away from zero, then saturate
  always_comb begin
    rnd_sum = fin_q + FIN_W'(RoundHalf) - FIN_W'(fin_q[FIN_W-1]);
    rnd     = rnd_sum[FIN_W-1:RND_SHIFT];
    if (rnd > MAX_POS) begin
      res_d = MAX_POS[EW-1:0];
    end else if (rnd < MIN_NEG) begin
      res_d = MIN_NEG[EW-1:0];
    end else begin
      res_d = rnd[EW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q     <= '0;
      op2_q     <= '0;
      fin_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      op1_q     <= op_i;
      op2_q     <= op1_q;
      fin_vld_q <= op2_q.vld & op2_q.hi;
      res_vld_q <= fin_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    sum_q  <= sum_d;
    fin_q  <= fin_d;
    if (fin_vld_q) begin
      res_q <= res_d;
    end
  end

  assign sts_o.sum_done = op2_q.vld & op2_q.last & ~op2_q.scl;
  assign sts_o.res_vld  = res_vld_q;
  assign res_o          = res_q;

endmodule

`default_nettype wire

>>> rtl/core/trmm_seq.sv
// Sequencer: walks rows, columns and dot-product terms and drives the
// shared multiply unit and the memory addresses. Depends on trmm_pkg.
`default_nettype none

module trmm_seq #(
  parameter int unsigned DIM_W = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  logic [DIM_W:0]        m_i,
  input  logic [DIM_W:0]        n_i,
  input  logic                  unit_i,
  input  trmm_pkg::mul_sts_t    sts_i,
  output trmm_pkg::mul_op_t     op_o,
  output logic [2*DIM_W-1:0]    a_raddr_o,
  output logic [2*DIM_W-1:0]    b_raddr_o,
  output logic [2*DIM_W-1:0]    cell_addr_o,
  output logic                  busy_o
);

  import trmm_pkg::*;

  localparam int unsigned CTR_W = DIM_W + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MAC   = 6'b000010,
    S_DRAIN = 6'b000100,
    S_SLO   = 6'b001000,
    S_SHI   = 6'b010000,
    S_WB    = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CTR_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic [CTR_W-1:0] r_nxt, c_nxt, k_nxt;
  logic             k_last;

  assign r_nxt  = r_q + CTR_W'(1);
  assign c_nxt  = c_q + CTR_W'(1);
  assign k_nxt  = k_q + CTR_W'(1);
  assign k_last = (k_nxt == m_i);

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    op_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (go_i) begin
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        op_o.vld  = 1'b1;
        op_o.clr  = (k_q == r_q);
        op_o.unit = unit_i && (k_q == r_q);
        op_o.last = k_last;
        if (k_last) begin
          state_d = S_DRAIN;
        end else begin
          k_d = k_nxt;
        end
      end
      S_DRAIN: begin
        if (sts_i.sum_done) begin
          state_d = S_SLO;
        end
      end
      S_SLO: begin
        op_o.vld = 1'b1;
        op_o.scl = 1'b1;
        state_d  = S_SHI;
      end
      S_SHI: begin
        op_o.vld = 1'b1;
        op_o.scl = 1'b1;
        op_o.hi  = 1'b1;
        state_d  = S_WB;
      end
      S_WB: begin
        // Row r only reads rows at or below it, so it can go back in place
        if (sts_i.res_vld) begin
          if (c_nxt != n_i) begin
            c_d     = c_nxt;
            k_d     = r_q;
            state_d = S_MAC;
          end else if (r_nxt != m_i) begin
            r_d     = r_nxt;
            c_d     = '0;
            k_d     = r_nxt;
            state_d = S_MAC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

  assign a_raddr_o   = {r_q[DIM_W-1:0], k_q[DIM_W-1:0]};
  assign b_raddr_o   = {k_q[DIM_W-1:0], c_q[DIM_W-1:0]};
  assign cell_addr_o = {r_q[DIM_W-1:0], c_q[DIM_W-1:0]};
  assign busy_o      = (state_q != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/upper_triangular_matrix_multiply_unit.sv
// Top level of the upper triangular matrix multiply unit, B := alpha*triu(A)*B.
// Depends on trmm_pkg, trmm_store, trmm_mul and trmm_seq.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-------------------------------
//   request  | mode_i row_i col_i value_i              | taken when start & !busy
//   result   | read_value_o out_of_range_o             | valid_o strobe, one cycle
//   config   | cfg_idx_i cfg_wdata_i                   | written when cfg_we_i
//
// Element writes and reads follow back to back while the unit is not busy; a read
// returns its result on valid_o in the cycle after the request.
// During a compute request busy stays high while the single shared multiplier
// does one term per cycle of each dot product; after its terms every element
// is drained, scaled by alpha in two passes, rounded and written back. Zero
// sizes (after clipping to MAX_DIM) make compute a no-op.
// Reset (async, active low) clears control, sizes and unit, and sets alpha to
// 0x0100; the A and B memories are not cleared and hold nothing defined
// until written. The result side cannot stall: valid_o is a one-cycle strobe.
`default_nettype none

module upper_triangular_matrix_multiply_unit #(
  parameter int unsigned MAX_DIM    = 16,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [trmm_pkg::MODE_W-1:0]          mode_i,
  input  logic [trmm_pkg::IDX_W-1:0]           row_i,
  input  logic [trmm_pkg::IDX_W-1:0]           col_i,
  input  logic signed [trmm_pkg::VAL_W-1:0]    value_i,
  // Result channel
  output logic                                 valid_o,
  output logic signed [trmm_pkg::VAL_W-1:0]    read_value_o,
  output logic                                 out_of_range_o,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [trmm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [trmm_pkg::CFG_DAT_W-1:0]       cfg_wdata_i
);

  import trmm_pkg::*;

  // Stored element width is capped at the request field width
  localparam int unsigned EW    = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
  localparam int unsigned DIM_W = $clog2(MAX_DIM);
  localparam int unsigned CTR_W = DIM_W + 1;
  localparam int unsigned AW    = 2 * DIM_W;

  // Configuration registers
  logic [CNT_W-1:0]          row_cnt_q, col_cnt_q;
  logic                      unit_q;
  logic signed [ALPHA_W-1:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
      unit_q    <= 1'b0;
      alpha_q   <= ALPHA_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROWS:  row_cnt_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_COLS:  col_cnt_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_UNIT:  unit_q    <= cfg_wdata_i[0];
        CFG_ALPHA: alpha_q   <= cfg_wdata_i[ALPHA_W-1:0];
        default:   ;
      endcase
    end
  end

  // Sizes clipped to the array dimension
  logic [CTR_W-1:0] m_lim, n_lim;

  assign m_lim = (32'(row_cnt_q) > 32'(MAX_DIM)) ? CTR_W'(MAX_DIM) : CTR_W'(row_cnt_q);
  assign n_lim = (32'(col_cnt_q) > 32'(MAX_DIM)) ? CTR_W'(MAX_DIM) : CTR_W'(col_cnt_q);

  // Request decode
  logic          accept, in_dim, rd_req, go, oor;
  logic [AW-1:0] in_addr;

  assign accept  = start & ~busy;
  assign in_dim  = (32'(row_i) < 32'(MAX_DIM)) && (32'(col_i) < 32'(MAX_DIM));
  assign in_addr = {DIM_W'(row_i), DIM_W'(col_i)};
  assign rd_req  = accept && (mode_i == MODE_RD_B);
  assign go      = accept && (mode_i == MODE_COMPUTE) && (m_lim != '0) && (n_lim != '0);
  assign oor     = (32'(row_i) >= 32'(m_lim)) || (32'(col_i) >= 32'(n_lim));

  // Sequencer, multiply unit and memories
  mul_op_t       mul_op;
  mul_sts_t      mul_sts;
  logic [AW-1:0] seq_a_raddr, seq_b_raddr, cell_addr;
  logic [EW-1:0] a_rdata, b_rdata, mul_res;
  logic          a_we, b_we;
  logic [AW-1:0] b_waddr, b_raddr;
  logic [EW-1:0] b_wdata;

  trmm_seq #(
    .DIM_W (DIM_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .m_i         (m_lim),
    .n_i         (n_lim),
    .unit_i      (unit_q),
    .sts_i       (mul_sts),
    .op_o        (mul_op),
    .a_raddr_o   (seq_a_raddr),
    .b_raddr_o   (seq_b_raddr),
    .cell_addr_o (cell_addr),
    .busy_o      (busy)
  );

  trmm_mul #(
    .EW (EW)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (mul_op),
    .a_rdata_i (a_rdata),
    .b_rdata_i (b_rdata),
    .alpha_i   (alpha_q),
    .sts_o     (mul_sts),
    .res_o     (mul_res)
  );

  // Element writes land only inside the array; compute results take the
  // B write port while busy, when no request can be taken
  assign a_we    = accept && (mode_i == MODE_WR_A) && in_dim;
  assign b_we    = (accept && (mode_i == MODE_WR_B) && in_dim) || mul_sts.res_vld;
  assign b_waddr = mul_sts.res_vld ? cell_addr : in_addr;
  assign b_wdata = mul_sts.res_vld ? mul_res : value_i[EW-1:0];
  assign b_raddr = busy ? seq_b_raddr : in_addr;

  trmm_store #(
    .EW (EW),
    .AW (AW)
  ) u_store (
    .clk_i     (clk_i),
    .a_we_i    (a_we),
    .a_waddr_i (in_addr),
    .a_wdata_i (value_i[EW-1:0]),
    .a_raddr_i (seq_a_raddr),
    .a_rdata_o (a_rdata),
    .b_we_i    (b_we),
    .b_waddr_i (b_waddr),
    .b_wdata_i (b_wdata),
    .b_raddr_i (b_raddr),
    .b_rdata_o (b_rdata)
  );

  // Read result: strobe in the cycle after the request, lined up with the
  // registered memory data
  logic valid_q, oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= rd_req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req) begin
      oor_q <= oor;
    end
  end

  assign valid_o        = valid_q;
  assign out_of_range_o = oor_q;
  assign read_value_o   = oor_q ? '0 : VAL_W'(signed'(b_rdata));

endmodule

`default_nettype wire

>>> rtl/core/trmm_chk.sv
// Port-level checker for the upper triangular matrix multiply unit, bound
// to the top level. Depends on trmm_pkg.
`default_nettype none

module trmm_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic [trmm_pkg::MODE_W-1:0]         mode_i,
  input logic                                valid_o,
  input logic signed [trmm_pkg::VAL_W-1:0]   read_value_o,
  input logic                                out_of_range_o
);

  import trmm_pkg::*;

  logic rd_req;

  assign rd_req = start && !busy && (mode_i == MODE_RD_B);

  // Every read request returns exactly one result in the next cycle
  a_rd_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req |=> valid_o)
    else $error("read request without result strobe");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(rd_req))
    else $error("result strobe without read request");

  // Out-of-range reads return zero
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_of_range_o) |-> (read_value_o == '0))
    else $error("out-of-range read with nonzero value");

  // A read never starts a compute, so busy stays low while its result shows
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

endmodule

bind upper_triangular_matrix_multiply_unit trmm_chk u_trmm_chk (.*);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for upper_triangular_matrix_multiply_unit (B := alpha*triu(A)*B).
// Depends on trmm_pkg and the RTL under rtl/core; keeps its own shadow copy of A, B and
// the registers, and checks every read strobe against it.

module tb;
  import trmm_pkg::*;

  localparam int     Dim            = 16;       // MAX_DIM of the instance
  localparam int     CycleLimit     = 2_000_000;
  localparam int     Phases         = 12;
  localparam int     RoundsPerPhase = 5;
  localparam int     SettleCycles   = 4;        // covers a zero-size compute and the read pipe
  localparam longint MaxPos         = (longint'(1) << (VAL_W - 1)) - 1;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    oor;
  } read_result_t;

  // Shadow of the unit: element stores, registers and the reads still owed.
  class trmm_shadow;
    logic signed [VAL_W-1:0]   a_mem [Dim*Dim];
    logic signed [VAL_W-1:0]   b_mem [Dim*Dim];
    logic [CNT_W-1:0]          row_count;
    logic [CNT_W-1:0]          col_count;
    logic                      unit_diag;
    logic signed [ALPHA_W-1:0] alpha;
    read_result_t              pending_reads [$];
    int                        errors;

    function new();
      row_count = '0;
      col_count = '0;
      unit_diag = 1'b0;
      alpha     = ALPHA_RESET;
      errors    = 0;
    endfunction

    function int clip(logic [CNT_W-1:0] cnt);
      return (cnt > Dim) ? Dim : int'(cnt);
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_ROWS:  row_count = data[CNT_W-1:0];
        CFG_COLS:  col_count = data[CNT_W-1:0];
        CFG_UNIT:  unit_diag = data[0];
        CFG_ALPHA: alpha     = data[ALPHA_W-1:0];
        default:   ;
      endcase
    endfunction

    // Shift out 16 fraction bits, round half away from zero, clamp to the element width.
    function logic signed [VAL_W-1:0] round_sat(longint p);
      longint mag;
      longint q;
      mag = (p < 0) ? -p : p;
      q   = (mag + RoundHalf) >> RND_SHIFT;
      if (p < 0) begin
        if (q > MaxPos + 1) q = MaxPos + 1;
        return VAL_W'(-q);
      end
      if (q > MaxPos) q = MaxPos;
      return VAL_W'(q);
    endfunction

    // Every new element is formed from the old B, top row first.
    function void multiply_in_place();
      logic signed [VAL_W-1:0] next_b [Dim*Dim];
      int                      m;
      int                      n;
      longint                  acc;
      m = clip(row_count);
      n = clip(col_count);
      if (m == 0 || n == 0) return;
      next_b = b_mem;
      for (int r = 0; r < m; r++) begin
        for (int c = 0; c < n; c++) begin
          if (unit_diag) acc = longint'(b_mem[r*Dim+c]) * OneQ8;
          else acc = longint'(a_mem[r*Dim+r]) * longint'(b_mem[r*Dim+c]);
          for (int k = r + 1; k < m; k++)
            acc += longint'(a_mem[r*Dim+k]) * longint'(b_mem[k*Dim+c]);
          next_b[r*Dim+c] = round_sat(acc * longint'(alpha));
        end
      end
      b_mem = next_b;
    endfunction

    function void take_request(mode_e mode, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                               logic signed [VAL_W-1:0] value);
      read_result_t res;
      case (mode)
        MODE_WR_A:    a_mem[int'(row)*Dim+int'(col)] = value;
        MODE_WR_B:    b_mem[int'(row)*Dim+int'(col)] = value;
        MODE_COMPUTE: multiply_in_place();
        default: begin
          if (row >= clip(row_count) || col >= clip(col_count)) begin
            res.value = '0;
            res.oor   = 1'b1;
          end else begin
            res.value = b_mem[int'(row)*Dim+int'(col)];
            res.oor   = 1'b0;
          end
          pending_reads.push_back(res);
        end
      endcase
    endfunction

    function void check_read(logic signed [VAL_W-1:0] value, logic oor);
      read_result_t owed;
      if (pending_reads.size() == 0) begin
        errors++;
        $error("read result with no read pending: read_value %0d", value);
        return;
      end
      owed = pending_reads.pop_front();
      if (value !== owed.value) begin
        errors++;
        $error("read_value: expected %0d, got %0d", owed.value, value);
      end
      if (oor !== owed.oor) begin
        errors++;
        $error("out_of_range: expected %0b, got %0b", owed.oor, oor);
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  mode_e                   mode_i;
  logic [IDX_W-1:0]        row_i;
  logic [IDX_W-1:0]        col_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    valid_o;
  logic signed [VAL_W-1:0] read_value_o;
  logic                    out_of_range_o;
  logic                    cfg_we_i;
  cfg_idx_e                cfg_idx_i;
  logic [CFG_DAT_W-1:0]    cfg_wdata_i;

  trmm_shadow shadow;
  bit         gaps_on;
  int         m_eff;
  int         n_eff;
  int         cycle_count;

  // Per-phase sizes: two full-size phases, two above MAX_DIM, zero sizes, rest small.
  int rows_plan [Phases] = '{16, 31, 3, 0, 5, 1, 2, 6, 4, 16, 3, 2};
  int cols_plan [Phases] = '{16, 2, 4, 3, 0, 1, 6, 16, 2, 31, 5, 1};

  upper_triangular_matrix_multiply_unit #(
    .MAX_DIM    (Dim),
    .DATA_WIDTH (VAL_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .value_i        (value_i),
    .valid_o        (valid_o),
    .read_value_o   (read_value_o),
    .out_of_range_o (out_of_range_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // The result side cannot stall: take every strobe at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) shadow.check_read(read_value_o, out_of_range_o);
  end

  // Mostly small Q8.8 values so sums stay meaningful; some wide, some at the rails.
  function automatic logic signed [VAL_W-1:0] rand_elem();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return VAL_W'(int'($urandom_range(0, 1023)) - 512);
    if (pick < 75) return VAL_W'(int'($urandom_range(0, 8191)) - 4096);
    if (pick < 90) return VAL_W'($urandom);
    case ($urandom_range(0, 4))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0100;
      3:       return 16'shff00;
      default: return 16'sh0000;
    endcase
  endfunction

  // Pick an index inside the configured size, or anywhere when the size is zero.
  function automatic logic [IDX_W-1:0] pick_index(int size);
    if (size == 0) return IDX_W'($urandom_range(0, Dim - 1));
    return IDX_W'($urandom_range(0, size - 1));
  endfunction

  // Drop start, scramble the fields so idle values are not trusted, and wait.
  task automatic hold_off(int cycles);
    @(negedge clk_i);
    start   = 1'b0;
    mode_i  = mode_e'($urandom_range(0, 3));
    row_i   = IDX_W'($urandom);
    col_i   = IDX_W'($urandom);
    value_i = VAL_W'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  // Present one request and hold it until the unit takes it (start & !busy at the edge).
  task automatic send(mode_e mode, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                      logic signed [VAL_W-1:0] value);
    if (gaps_on && $urandom_range(0, 99) < 14) hold_off($urandom_range(1, 3));
    @(negedge clk_i);
    start   = 1'b1;
    mode_i  = mode;
    row_i   = row;
    col_i   = col;
    value_i = value;
    do @(posedge clk_i); while (busy);
    shadow.take_request(mode, row, col, value);
  endtask

  // Stop sending and wait for the unit to go quiet: no read owed, no compute running.
  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    do @(posedge clk_i); while (shadow.pending_reads.size() != 0 || busy);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    shadow.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(int rows, int cols, bit unit, logic signed [ALPHA_W-1:0] alpha);
    write_reg(CFG_ROWS, CFG_DAT_W'(rows));
    write_reg(CFG_COLS, CFG_DAT_W'(cols));
    write_reg(CFG_UNIT, CFG_DAT_W'(unit));
    write_reg(CFG_ALPHA, CFG_DAT_W'(alpha));
    m_eff = shadow.clip(CNT_W'(rows));
    n_eff = shadow.clip(CNT_W'(cols));
  endtask

  initial begin
    shadow      = new();
    gaps_on     = 1'b1;
    m_eff       = 0;
    n_eff       = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    mode_i      = MODE_WR_A;
    row_i       = '0;
    col_i       = '0;
    value_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_ROWS;
    cfg_wdata_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Load every element of A and B first: no read or compute may touch an unwritten entry.
    for (int r = 0; r < Dim; r++)
      for (int c = 0; c < Dim; c++) send(MODE_WR_A, IDX_W'(r), IDX_W'(c), rand_elem());
    for (int r = 0; r < Dim; r++)
      for (int c = 0; c < Dim; c++) send(MODE_WR_B, IDX_W'(r), IDX_W'(c), rand_elem());

    // Reset sizes are zero: reads fall outside, compute does nothing.
    send(MODE_RD_B, 4'd0, 4'd0, 16'sh0000);
    send(MODE_COMPUTE, 4'd15, 4'd15, 16'sh7fff);
    send(MODE_RD_B, 4'd15, 4'd15, 16'sh8000);
    settle();

    // Small 2x3 case with rail values on both operands and a below-diagonal entry.
    configure(2, 3, 1'b0, 16'sh0100);
    send(MODE_WR_A, 4'd0, 4'd0, 16'sh7fff);
    send(MODE_WR_A, 4'd0, 4'd1, 16'sh8000);
    send(MODE_WR_A, 4'd1, 4'd1, 16'sh0100);
    send(MODE_WR_A, 4'd1, 4'd0, 16'shffff);
    send(MODE_WR_B, 4'd0, 4'd0, 16'sh0100);
    send(MODE_WR_B, 4'd0, 4'd1, 16'sh8000);
    send(MODE_WR_B, 4'd0, 4'd2, 16'sh7fff);
    send(MODE_WR_B, 4'd1, 4'd0, 16'sh0000);
    send(MODE_WR_B, 4'd1, 4'd1, 16'shff00);
    send(MODE_WR_B, 4'd1, 4'd2, 16'sh0001);
    send(MODE_COMPUTE, 4'd0, 4'd0, 16'sh0000);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++) send(MODE_RD_B, IDX_W'(r), IDX_W'(c), 16'sh0000);
    send(MODE_RD_B, 4'd2, 4'd0, 16'sh0000);
    send(MODE_RD_B, 4'd0, 4'd3, 16'sh0000);
    send(MODE_RD_B, 4'd15, 4'd15, 16'sh0000);

    // Random phases: each one rewrites every register while the unit is quiet, then runs
    // rounds of load, compute, read back, plus one stray request of any kind.
    for (int p = 0; p < Phases; p++) begin
      settle();
      configure(rows_plan[p], cols_plan[p],
                (p == 1 || p == 2) ? 1'b1 : (p == 0) ? 1'b0 : 1'($urandom_range(0, 1)),
                (p == 0) ? 16'sh0100 : (p == 1) ? 16'sh8000 : (p == 2) ? 16'sh7fff :
                (p == 3) ? 16'sh0000 : ($urandom_range(0, 1) != 0) ?
                VAL_W'(int'($urandom_range(0, 1023)) - 512) : VAL_W'($urandom));
      gaps_on = (p != 5);  // one phase runs back to back with no idle cycles
      for (int r = 0; r < RoundsPerPhase; r++) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) != 0)
            send(MODE_WR_B, pick_index(m_eff), pick_index(n_eff), rand_elem());
          else
            send(MODE_WR_A, pick_index(m_eff), pick_index(m_eff), rand_elem());
        end
        send(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
        repeat ($urandom_range(2, 6))
          send(MODE_RD_B, pick_index(m_eff), pick_index(n_eff), VAL_W'($urandom));
        send(mode_e'($urandom_range(0, 3)), IDX_W'($urandom), IDX_W'($urandom), rand_elem());
      end
    end

    settle();
    if (shadow.pending_reads.size() != 0) begin
      shadow.errors++;
      $error("%0d reads never returned", shadow.pending_reads.size());
    end
    if (shadow.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
